/* rtl/core/lsr_pkg.sv */
// Shared types and constants for the linear setpoint ramp.
package lsr_pkg;

    localparam int AXES      = 4;
    localparam int MAX_STEPS = 65535;
    localparam int PORT_AXES = 4;
    localparam int POS_W     = 32;
    localparam int STEP_W    = POS_W + 1;
    localparam int CNT_W     = 16;
    localparam int ACT_W     = 2;
    localparam int AXIS_W    = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int DIV_CNT_W = $clog2(STEP_W);

    typedef logic signed [POS_W-1:0]  pos_t;
    typedef logic signed [STEP_W-1:0] step_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_TICK        = 2'd0,
        ACT_START_HELD  = 2'd1,
        ACT_START_GIVEN = 2'd2,
        ACT_STOP        = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WAIT
    } ramp_state_t;

    typedef struct packed {
        logic  done;
        step_t quotient;
    } div_result_t;

endpackage

/* rtl/core/lsr_div.sv */
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
module lsr_div
    import lsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  step_t       dividend,
    input  cnt_t        divisor,
    output div_result_t result
);

    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     rem_next;
    logic [STEP_W-1:0]    quo_reg;
    logic [STEP_W-1:0]    quo_next;
    cnt_t                 dvs_reg;
    logic                 neg_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [CNT_W:0]       trial;
    logic [CNT_W:0]       diff;
    logic                 ge;
    logic [STEP_W-1:0]    magnitude;

    assign magnitude = dividend[STEP_W-1] ? (~dividend + 1'b1) : dividend;

    // Shift one dividend bit into the partial remainder, subtract when it fits.
    assign trial    = {rem_reg, quo_reg[STEP_W-1]};
    assign ge       = (trial >= {1'b0, dvs_reg});
    assign diff     = trial - {1'b0, dvs_reg};
    assign rem_next = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    assign quo_next = {quo_reg[STEP_W-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                if (cnt_reg == DIV_CNT_W'(STEP_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= '0;
            quo_reg <= magnitude;
            dvs_reg <= divisor;
            neg_reg <= dividend[STEP_W-1];
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign result.done     = done_reg;
    assign result.quotient = neg_reg ? step_t'(~quo_reg + 1'b1) : step_t'(quo_reg);

endmodule

/* rtl/core/linear_setpoint_ramp.sv */
// Multi-axis linear setpoint ramp generator, signed Q16.16 positions.
// Tick, stop and refused start: the result is registered at the transfer.
// Taken start: input stalls while the shared divider forms each axis step, one quotient
//   bit per cycle, one axis after another.
// Reset (rst_n, async, active low): held/origin/step zero, count done 0 of 1, not busy,
//   no result pending.
module linear_setpoint_ramp
    import lsr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [ACT_W-1:0]   action,
    input  logic [CNT_W-1:0]   step_count,
    input  logic signed [31:0] target_0,
    input  logic signed [31:0] target_1,
    input  logic signed [31:0] target_2,
    input  logic signed [31:0] target_3,
    input  logic signed [31:0] start_0,
    input  logic signed [31:0] start_1,
    input  logic signed [31:0] start_2,
    input  logic signed [31:0] start_3,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               accepted,
    output logic               point_valid,
    output logic signed [31:0] point_0,
    output logic signed [31:0] point_1,
    output logic signed [31:0] point_2,
    output logic signed [31:0] point_3
);

    // Ramp state.
    pos_t        held_reg   [AXES];
    pos_t        held_next  [AXES];
    pos_t        acc_reg    [AXES];   // origin + steps_done * step, tracked by addition
    pos_t        origin_reg [AXES];
    pos_t        tgt_reg    [AXES];
    step_t       step_reg   [AXES];
    cnt_t        done_cnt_reg;
    cnt_t        total_reg;
    logic        busy_reg;

    // Sequencer for the per-axis divisions.
    ramp_state_t state_reg;
    ramp_state_t state_next;
    logic [AXIS_W-1:0] axis_reg;
    logic        div_go;
    div_result_t div_res;
    step_t       dividend;

    // Result register.
    logic        out_valid_reg;
    logic        accepted_reg;
    logic        accepted_next;
    logic        pvalid_reg;
    logic        pvalid_next;
    pos_t        point_reg  [PORT_AXES];
    pos_t        point_next [PORT_AXES];

    // Decoded input.
    action_t     act;
    pos_t        tgt_in     [PORT_AXES];
    pos_t        start_in   [PORT_AXES];
    logic        in_fire;
    logic        is_start;
    logic        start_take;
    logic        tick_adv;
    cnt_t        n_sel;

    assign act = action_t'(action);

    assign tgt_in[0]   = target_0;
    assign tgt_in[1]   = target_1;
    assign tgt_in[2]   = target_2;
    assign tgt_in[3]   = target_3;
    assign start_in[0] = start_0;
    assign start_in[1] = start_1;
    assign start_in[2] = start_2;
    assign start_in[3] = start_3;

    // Take a new item only while no division runs and the result slot is free
    // or draining this cycle.
    assign in_stall = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign in_fire  = in_valid && !in_stall;

    assign is_start   = (act == ACT_START_HELD) || (act == ACT_START_GIVEN);
    assign start_take = in_fire && is_start && !busy_reg;
    assign tick_adv   = in_fire && (act == ACT_TICK) && (done_cnt_reg < total_reg);

    // Zero steps count as one; clamp to the longest ramp.
    always_comb
    begin
        n_sel = (step_count == '0) ? cnt_t'(1) : step_count;
        if (n_sel > cnt_t'(MAX_STEPS))
        begin
            n_sel = cnt_t'(MAX_STEPS);
        end
    end

    // Next held point: on a valid tick, every axis takes its accumulated position plus its step, else hold.
    always_comb
    begin
        logic signed [POS_W+1:0] sum;
        for (int a = 0; a < AXES; a++)
        begin
            sum = {{2{acc_reg[a][POS_W-1]}}, acc_reg[a]}
                + {step_reg[a][STEP_W-1], step_reg[a]};
            held_next[a] = tick_adv ? sum[POS_W-1:0] : held_reg[a];
        end
    end

    // Every result shows the held point after the item; unused axes read zero.
    always_comb
    begin
        accepted_next = !(is_start && busy_reg);
        pvalid_next   = tick_adv;
        for (int p = 0; p < PORT_AXES; p++)
        begin
            point_next[p] = '0;
        end
        for (int a = 0; a < AXES; a++)
        begin
            point_next[a] = held_next[a];
        end
    end

    // Sequencer: load the divider for one axis, wait for its quotient, move on.
    always_comb
    begin
        state_next = state_reg;
        div_go     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_take)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                div_go     = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_res.done)
                begin
                    state_next = (axis_reg == AXIS_W'(AXES - 1)) ? ST_IDLE : ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign dividend = {tgt_reg[axis_reg][POS_W-1], tgt_reg[axis_reg]}
                    - {origin_reg[axis_reg][POS_W-1], origin_reg[axis_reg]};

    lsr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (dividend),
        .divisor  (total_reg),
        .result   (div_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            axis_reg     <= '0;
            done_cnt_reg <= '0;
            total_reg    <= cnt_t'(1);
            busy_reg     <= 1'b0;
            for (int a = 0; a < AXES; a++)
            begin
                held_reg[a]   <= '0;
                acc_reg[a]    <= '0;
                origin_reg[a] <= '0;
                step_reg[a]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            for (int a = 0; a < AXES; a++)
            begin
                held_reg[a] <= held_next[a];
            end

            if (in_fire)
            begin
                case (act)
                    ACT_TICK:
                    begin
                        if (tick_adv)
                        begin
                            done_cnt_reg <= done_cnt_reg + 1'b1;
                            busy_reg     <= 1'b1;
                            for (int a = 0; a < AXES; a++)
                            begin
                                acc_reg[a] <= held_next[a];
                            end
                        end
                        else
                        begin
                            busy_reg <= 1'b0;
                        end
                    end
                    ACT_STOP:
                    begin
                        done_cnt_reg <= total_reg;
                        busy_reg     <= 1'b0;
                    end
                    default:
                    begin
                        // Start: fix origin and count; steps follow from the divider.
                        if (!busy_reg)
                        begin
                            total_reg    <= n_sel;
                            done_cnt_reg <= '0;
                            busy_reg     <= 1'b1;
                            axis_reg     <= '0;
                            for (int a = 0; a < AXES; a++)
                            begin
                                origin_reg[a] <= (act == ACT_START_GIVEN) ? start_in[a]
                                                                          : held_reg[a];
                                acc_reg[a]    <= (act == ACT_START_GIVEN) ? start_in[a]
                                                                          : held_reg[a];
                            end
                        end
                    end
                endcase
            end

            if ((state_reg == ST_WAIT) && div_res.done)
            begin
                step_reg[axis_reg] <= div_res.quotient;
                axis_reg           <= axis_reg + 1'b1;
            end
        end
    end

    // Targets are only read by the divider; no reset needed.
    always_ff @(posedge clk)
    begin
        if (start_take)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                tgt_reg[a] <= tgt_in[a];
            end
        end
    end

    // Output register: load on every input transfer, drop once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            accepted_reg <= accepted_next;
            pvalid_reg   <= pvalid_next;
            for (int p = 0; p < PORT_AXES; p++)
            begin
                point_reg[p] <= point_next[p];
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign accepted    = accepted_reg;
    assign point_valid = pvalid_reg;
    assign point_0     = point_reg[0];
    assign point_1     = point_reg[1];
    assign point_2     = point_reg[2];
    assign point_3     = point_reg[3];

    // The ramp position never passes its total.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done_cnt_reg <= total_reg)
        else $error("step counter beyond ramp length");

    // A ramp always has at least one step.
    a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg != '0)
        else $error("zero ramp length");

    // A quotient only arrives while the sequencer waits for it.
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == ST_WAIT))
        else $error("divider result outside wait state");

    // A taken start launches the division sequence.
    a_start_launch: assert property (@(posedge clk) disable iff (!rst_n)
        start_take |=> (state_reg == ST_LOAD) && busy_reg)
        else $error("taken start did not launch division");

endmodule

/* tb/sv/linear_setpoint_ramp_test.sv */
// Self-checking testbench for the linear setpoint ramp: directed and random ramp traffic.
module linear_setpoint_ramp_test;
    import lsr_pkg::*;

    // One command as the sender presents it, and one setpoint as the receiver sees it.
    typedef struct packed {
        action_t                 act;
        cnt_t                    cnt;
        pos_t [PORT_AXES-1:0]    tgt;
        pos_t [PORT_AXES-1:0]    org;
    } ramp_cmd_t;

    typedef struct packed {
        logic                    ack;
        logic                    fresh;
        pos_t [PORT_AXES-1:0]    pos;
    } setpoint_t;

    localparam int CLK_HALF    = 4;
    localparam int LIMIT_TICKS = 1_000_000;
    localparam int DRAIN_TICKS = 16;
    localparam int RANDOM_ITEMS = 580;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [ACT_W-1:0]   action = ACT_TICK;
    logic [CNT_W-1:0]   step_count = '0;
    logic signed [31:0] target_0 = '0;
    logic signed [31:0] target_1 = '0;
    logic signed [31:0] target_2 = '0;
    logic signed [31:0] target_3 = '0;
    logic signed [31:0] start_0 = '0;
    logic signed [31:0] start_1 = '0;
    logic signed [31:0] start_2 = '0;
    logic signed [31:0] start_3 = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               accepted;
    logic               point_valid;
    logic signed [31:0] point_0;
    logic signed [31:0] point_1;
    logic signed [31:0] point_2;
    logic signed [31:0] point_3;

    // Ramp state as the testbench tracks it.
    pos_t    held_pos [PORT_AXES] = '{default: '0};
    longint  origin_pos [PORT_AXES] = '{default: 0};
    longint  axis_incr [PORT_AXES] = '{default: 0};
    int      ticks_done = 0;
    int      ticks_total = 1;
    bit      ramp_busy = 1'b0;

    setpoint_t pending_points [$];
    setpoint_t seen_point;
    setpoint_t want_point;
    int        mismatch_count = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    linear_setpoint_ramp dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .step_count  (step_count),
        .target_0    (target_0),
        .target_1    (target_1),
        .target_2    (target_2),
        .target_3    (target_3),
        .start_0     (start_0),
        .start_1     (start_1),
        .start_2     (start_2),
        .start_3     (start_3),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .accepted    (accepted),
        .point_valid (point_valid),
        .point_0     (point_0),
        .point_1     (point_1),
        .point_2     (point_2),
        .point_3     (point_3)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Advance the tracked ramp by one accepted command and return the setpoint it yields.
    function automatic setpoint_t advance_ramp(input ramp_cmd_t c);
        setpoint_t r;
        longint    n;
        longint    from;
        longint    to;
        r.ack   = 1'b1;
        r.fresh = 1'b0;
        case (c.act)
            ACT_TICK:
            begin
                // Emit the next point while steps remain; otherwise repeat the held one.
                if (ticks_done < ticks_total)
                begin
                    ticks_done++;
                    for (int a = 0; a < AXES; a++)
                        held_pos[a] = pos_t'(origin_pos[a] + longint'(ticks_done) * axis_incr[a]);
                    ramp_busy = 1'b1;
                    r.fresh   = 1'b1;
                end
                else
                    ramp_busy = 1'b0;
            end
            ACT_STOP:
            begin
                ticks_done = ticks_total;
                ramp_busy  = 1'b0;
            end
            default:
            begin
                if (ramp_busy)
                    r.ack = 1'b0;
                else
                begin
                    // A zero count behaves as a single step.
                    n = (c.cnt == '0) ? 1 : longint'(c.cnt);
                    if (n > MAX_STEPS)
                        n = MAX_STEPS;
                    for (int a = 0; a < AXES; a++)
                    begin
                        from = (c.act == ACT_START_GIVEN) ? longint'($signed(c.org[a]))
                                                          : longint'(held_pos[a]);
                        to = longint'($signed(c.tgt[a]));
                        origin_pos[a] = from;
                        // Signed division truncates toward zero, as required.
                        axis_incr[a] = (to - from) / n;
                    end
                    ticks_total = int'(n);
                    ticks_done  = 0;
                    ramp_busy   = 1'b1;
                end
            end
        endcase
        for (int a = 0; a < PORT_AXES; a++)
            r.pos[a] = (a < AXES) ? held_pos[a] : '0;
        return r;
    endfunction

    // Pick a position: full-range half the time, else small values or the extremes.
    function automatic pos_t rand_pos();
        pos_t p;
        case ($urandom_range(3))
            0: p = pos_t'(int'($urandom_range(0, 200000)) - 100000);
            1:
            begin
                case ($urandom_range(3))
                    0: p = 32'sh8000_0000;
                    1: p = 32'sh7fff_ffff;
                    2: p = '0;
                    default: p = -32'sd1;
                endcase
            end
            default: p = pos_t'($urandom);
        endcase
        return p;
    endfunction

    function automatic ramp_cmd_t make_cmd(input action_t act, input int n);
        ramp_cmd_t c;
        c.act = act;
        c.cnt = cnt_t'(n);
        for (int a = 0; a < PORT_AXES; a++)
        begin
            c.tgt[a] = rand_pos();
            c.org[a] = rand_pos();
        end
        return c;
    endfunction

    // Present one command, hold it through any stall, and record its expected setpoint.
    task automatic send_cmd(input ramp_cmd_t c);
        // Idle cycle by cycle at the rate the current phase asks for.
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        action     <= c.act;
        step_count <= c.cnt;
        target_0   <= c.tgt[0];
        target_1   <= c.tgt[1];
        target_2   <= c.tgt[2];
        target_3   <= c.tgt[3];
        start_0    <= c.org[0];
        start_1    <= c.org[1];
        start_2    <= c.org[2];
        start_3    <= c.org[3];
        in_valid   <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_points.push_back(advance_ramp(c));
    endtask

    task automatic note_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endtask

    // Compare each setpoint transfer with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_point.ack    = accepted;
            seen_point.fresh  = point_valid;
            seen_point.pos[0] = point_0;
            seen_point.pos[1] = point_1;
            seen_point.pos[2] = point_2;
            seen_point.pos[3] = point_3;
            if (pending_points.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected setpoint transfer, expected none, actual %0d/%0d",
                         $time, accepted, point_valid);
            end
            else
            begin
                want_point = pending_points.pop_front();
                if (seen_point.ack !== want_point.ack)
                    note_mismatch("accepted", want_point.ack, seen_point.ack);
                if (seen_point.fresh !== want_point.fresh)
                    note_mismatch("point_valid", want_point.fresh, seen_point.fresh);
                for (int a = 0; a < PORT_AXES; a++)
                    if (seen_point.pos[a] !== want_point.pos[a])
                        note_mismatch($sformatf("point_%0d", a),
                                      longint'(want_point.pos[a]), longint'(seen_point.pos[a]));
            end
        end
        // Stall the result side at the rate the current phase asks for.
        out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end

    // After reset the count is one step of zero size: the first tick emits zero as valid.
    task automatic test_first_tick();
        send_cmd(make_cmd(ACT_TICK, 7));
        send_cmd(make_cmd(ACT_TICK, 0));
    endtask

    // Span the whole position range in one step, then return from the held point.
    task automatic test_extreme_spans();
        ramp_cmd_t c;
        c = make_cmd(ACT_START_GIVEN, 1);
        c.tgt = {32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, -32'sd1};
        c.org = {32'sh8000_0000, 32'sh7fff_ffff, -32'sd1, 32'sh7fff_ffff};
        send_cmd(c);
        send_cmd(make_cmd(ACT_TICK, 0));
        send_cmd(make_cmd(ACT_TICK, 0));
        // Zero count from the held point behaves as one step.
        c = make_cmd(ACT_START_HELD, 0);
        c.tgt = {32'sh8000_0000, 32'sh7fff_ffff, '0, 32'sh8000_0000};
        send_cmd(c);
        send_cmd(make_cmd(ACT_TICK, 0));
        send_cmd(make_cmd(ACT_TICK, 0));
    endtask

    // Refuse starts while busy, truncate odd spans toward zero, and stop mid-ramp.
    task automatic test_refused_and_stop();
        ramp_cmd_t c;
        c = make_cmd(ACT_START_GIVEN, 3);
        c.tgt = {32'sd7, -32'sd7, -32'sd3, 32'sd3};
        c.org = '0;
        send_cmd(c);
        send_cmd(make_cmd(ACT_START_HELD, 2));
        send_cmd(make_cmd(ACT_START_GIVEN, 5));
        send_cmd(make_cmd(ACT_TICK, 0));
        send_cmd(make_cmd(ACT_STOP, 9));
        send_cmd(make_cmd(ACT_TICK, 0));
        send_cmd(make_cmd(ACT_STOP, 0));
    endtask

    // Longest ramps in both directions, cut short by stop.
    task automatic test_longest_ramp();
        ramp_cmd_t c;
        c = make_cmd(ACT_START_GIVEN, MAX_STEPS);
        c.tgt = {4{32'sh7fff_ffff}};
        c.org = {4{32'sh8000_0000}};
        send_cmd(c);
        send_cmd(make_cmd(ACT_TICK, 0));
        send_cmd(make_cmd(ACT_TICK, 0));
        send_cmd(make_cmd(ACT_STOP, 0));
        c = make_cmd(ACT_START_HELD, MAX_STEPS);
        c.tgt = {4{32'sh8000_0000}};
        send_cmd(c);
        send_cmd(make_cmd(ACT_TICK, 0));
        send_cmd(make_cmd(ACT_STOP, 0));
    endtask

    // Mostly whole ramps with random content, plus random noise and refused starts.
    task automatic test_random_ramps(input int count);
        int sent;
        int n;
        int r;
        int ticks;
        bit cut;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 20)
            begin
                send_cmd(make_cmd(action_t'($urandom_range(3)), $urandom_range(0, 65535)));
                sent++;
            end
            else
            begin
                // Clear a running ramp first most of the time so the start gets taken.
                if (ramp_busy && $urandom_range(3) != 0)
                begin
                    send_cmd(make_cmd(ACT_STOP, $urandom_range(0, 65535)));
                    sent++;
                end
                r = $urandom_range(99);
                if (r < 60)
                    n = $urandom_range(0, 6);
                else if (r < 85)
                    n = $urandom_range(7, 40);
                else if (r < 95)
                    n = $urandom_range(0, 65535);
                else
                    n = MAX_STEPS;
                send_cmd(make_cmd($urandom_range(1) ? ACT_START_GIVEN : ACT_START_HELD, n));
                sent++;
                // Short ramps run out and may repeat the held point, or are stopped early; long ones get stopped.
                cut = (n > 40) || ($urandom_range(99) < 20);
                ticks = (n > 40) ? $urandom_range(0, 30)
                      : cut ? $urandom_range(0, n) : n + $urandom_range(0, 2);
                for (int k = 0; k < ticks; k++)
                begin
                    if ($urandom_range(99) < 5)
                        send_cmd(make_cmd($urandom_range(1) ? ACT_START_GIVEN : ACT_START_HELD,
                                          $urandom_range(0, 65535)));
                    else
                        send_cmd(make_cmd(ACT_TICK, $urandom_range(0, 65535)));
                    sent++;
                end
                if (cut)
                begin
                    send_cmd(make_cmd(ACT_STOP, $urandom_range(0, 65535)));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 30;
        recv_idle_pct = 49;
        test_first_tick();
        test_extreme_spans();
        test_refused_and_stop();
        test_longest_ramp();
        test_random_ramps(RANDOM_ITEMS);
        send_idle_pct = 49;
        recv_idle_pct = 30;
        test_random_ramps(RANDOM_ITEMS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_ramps(RANDOM_ITEMS);
        in_valid <= 1'b0;
        // Drain outstanding setpoints, then watch for strays.
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TICKS) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Give up if the run hangs.
    initial
    begin
        #(2 * CLK_HALF * LIMIT_TICKS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/lsr_pkg.sv
rtl/core/lsr_div.sv
rtl/core/linear_setpoint_ramp.sv
tb/sv/linear_setpoint_ramp_test.sv
